// File: hdl/lcdw_pkg.sv
// shared constants, item types and command codes for the lcd window write controller
package lcdw_pkg;

    localparam int ROW_SHIFT    = 8;
    localparam int ADDR_BITS    = 16;
    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 128;

    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_COLSET = 8'h2A;
    localparam logic [7:0] OP_ROWSET = 8'h2B;
    localparam logic [7:0] OP_MEMWR  = 8'h2C;

    localparam logic [7:0] COL_LIMIT = 8'h83;
    localparam logic [7:0] ROW_LIMIT = 8'hA1;
    localparam logic [8:0] IDX_MAX   = 9'd511;

    localparam logic [8:0] IDX_START_PARAM = 9'd1;
    localparam logic [8:0] IDX_END_PARAM   = 9'd3;

    localparam logic [7:0] COL_END_RST = 8'(PANEL_WIDTH - 1);
    localparam logic [7:0] ROW_END_RST = 8'(PANEL_HEIGHT - 1);

    typedef struct packed {
        logic       write_strobe;
        logic       data_select;
        logic       chip_select_n;
        logic [7:0] bus_data;
        logic       take_count;
    } t_in_item;

    typedef struct packed {
        logic        fb_write;
        logic [15:0] fb_address;
        logic [7:0]  fb_byte;
        logic [31:0] write_cmd_count;
    } t_out_item;

endpackage

// File: hdl/lcd_window_write_controller_top.sv
// top level of the lcd window write controller
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   write_strobe data_select chip_select_n
//                                                bus_data take_count
// out       output     o_out_valid / i_out_stall fb_write fb_address fb_byte write_cmd_count
//
// one item per cycle sustained while the output is not stalled; an item is taken into the
// input register, then its result into the result register, from which it is on the outputs
// the window state updates as an item moves from the input register to the result register
// reset clears both valid flags and the window state, no clearing pass
// a stall on the output holds the result and backs up into o_in_stall only when both
// registers are full
module lcd_window_write_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_write_strobe,
    input  logic        i_data_select,
    input  logic        i_chip_select_n,
    input  logic [7:0]  i_bus_data,
    input  logic        i_take_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_fb_write,
    output logic [15:0] o_fb_address,
    output logic [7:0]  o_fb_byte,
    output logic [31:0] o_write_cmd_count
);
    import lcdw_pkg::*;

    t_in_item  w_in_item;
    t_in_item  w_s1_item;
    t_out_item w_core_res;
    t_out_item w_out_res;
    logic      w_s1_valid;
    logic      w_out_ready;
    logic      w_adv;

    assign w_in_item.write_strobe  = i_write_strobe;
    assign w_in_item.data_select   = i_data_select;
    assign w_in_item.chip_select_n = i_chip_select_n;
    assign w_in_item.bus_data      = i_bus_data;
    assign w_in_item.take_count    = i_take_count;

    assign w_adv = w_s1_valid && w_out_ready;

    lcdw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (w_in_item),
        .i_adv   (w_adv),
        .o_stall (o_in_stall),
        .o_valid (w_s1_valid),
        .o_item  (w_s1_item)
    );

    lcdw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (w_s1_item),
        .o_result (w_core_res)
    );

    lcdw_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_result (w_core_res),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_out_res)
    );

    assign o_fb_write        = w_out_res.fb_write;
    assign o_fb_address      = w_out_res.fb_address;
    assign o_fb_byte         = w_out_res.fb_byte;
    assign o_write_cmd_count = w_out_res.write_cmd_count;

endmodule

// File: hdl/lcdw_in_stage.sv
// input register stage holding one sampled bus item
module lcdw_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lcdw_pkg::t_in_item i_item,
    input  logic              i_adv,
    output logic              o_stall,
    output logic              o_valid,
    output lcdw_pkg::t_in_item o_item
);
    import lcdw_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_adv) begin
            r_item <= i_item;
        end
    end

    assign o_stall = r_valid && !i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/lcdw_core.sv
// command decode, window state and framebuffer address generation
module lcdw_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  lcdw_pkg::t_in_item  i_item,
    output lcdw_pkg::t_out_item o_result
);
    import lcdw_pkg::*;

    logic        r_last_strobe, n_last_strobe;
    logic [7:0]  r_cmd, n_cmd;
    logic [8:0]  r_idx, n_idx;
    logic [7:0]  r_col_start, n_col_start;
    logic [7:0]  r_col_end, n_col_end;
    logic [7:0]  r_row_start, n_row_start;
    logic [7:0]  r_row_end, n_row_end;
    logic [7:0]  r_row, n_row;
    logic [31:0] r_count, n_count;

    logic                 w_edge;
    logic                 w_memwr_cmd;
    logic [ADDR_BITS-1:0] w_addr;
    logic [8:0]           w_idx_inc;
    logic [9:0]           w_idx_lim;
    logic [7:0]           w_row_inc;
    logic [7:0]           w_clamped;

    function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] hi);
        return (v > hi) ? hi : v;
    endfunction

    assign w_edge    = i_item.write_strobe && !r_last_strobe && !i_item.chip_select_n;
    assign w_addr    = (ADDR_BITS'(r_row) << ROW_SHIFT) + ADDR_BITS'(r_idx);
    assign w_idx_inc = r_idx + 9'd1;
    assign w_idx_lim = {1'b0, r_col_end, 1'b0} + 10'd1;
    assign w_row_inc = r_row + 8'd1;
    assign w_clamped = clamp(i_item.bus_data, (r_cmd == OP_COLSET) ? COL_LIMIT : ROW_LIMIT);

    always_comb begin
        n_last_strobe = i_item.write_strobe;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_col_start   = r_col_start;
        n_col_end     = r_col_end;
        n_row_start   = r_row_start;
        n_row_end     = r_row_end;
        n_row         = r_row;
        w_memwr_cmd   = 1'b0;
        o_result      = '0;
        o_result.write_cmd_count = r_count;

        if (w_edge && !i_item.data_select) begin
            n_cmd = i_item.bus_data;
            n_idx = '0;
            if (i_item.bus_data == OP_MEMWR) begin
                n_row       = r_row_start;
                n_idx       = {r_col_start, 1'b0};
                w_memwr_cmd = 1'b1;
            end
        end else if (w_edge) begin
            case (r_cmd)
                OP_COLSET, OP_ROWSET: begin
                    if (r_idx == IDX_START_PARAM) begin
                        if (r_cmd == OP_COLSET) n_col_start = w_clamped;
                        else                    n_row_start = w_clamped;
                    end else if (r_idx == IDX_END_PARAM) begin
                        if (r_cmd == OP_COLSET) n_col_end = w_clamped;
                        else                    n_row_end = w_clamped;
                    end
                    // counter saturates on long parameter streams
                    if (r_idx < IDX_MAX) n_idx = w_idx_inc;
                end
                OP_MEMWR: begin
                    o_result.fb_write   = 1'b1;
                    o_result.fb_byte    = i_item.bus_data;
                    o_result.fb_address = w_addr[15:0];
                    n_idx = w_idx_inc;
                    if ({1'b0, w_idx_inc} > w_idx_lim) begin
                        n_idx = {r_col_start, 1'b0};
                        n_row = (w_row_inc > r_row_end) ? r_row_start : w_row_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        n_count = i_item.take_count ? 32'd0 : r_count;
        if (w_memwr_cmd) n_count = n_count + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_strobe <= 1'b0;
            r_cmd         <= OP_NOP;
            r_idx         <= '0;
            r_col_start   <= '0;
            r_col_end     <= COL_END_RST;
            r_row_start   <= '0;
            r_row_end     <= ROW_END_RST;
            r_row         <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_last_strobe <= n_last_strobe;
            r_cmd         <= n_cmd;
            r_idx         <= n_idx;
            r_col_start   <= n_col_start;
            r_col_end     <= n_col_end;
            r_row_start   <= n_row_start;
            r_row_end     <= n_row_end;
            r_row         <= n_row;
            r_count       <= n_count;
        end
    end

endmodule

// File: hdl/lcdw_out_stage.sv
// result register facing the framebuffer side
module lcdw_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  lcdw_pkg::t_out_item i_result,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output lcdw_pkg::t_out_item o_result
);
    import lcdw_pkg::*;

    logic      r_valid;
    t_out_item r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hdl/lcdw_checker.sv
// port-level checks for the lcd window write controller, bound to the top level
module lcdw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_write_strobe,
    input logic        i_data_select,
    input logic        i_chip_select_n,
    input logic [7:0]  i_bus_data,
    input logic        i_take_count,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_fb_write,
    input logic [15:0] o_fb_address,
    input logic [7:0]  o_fb_byte,
    input logic [31:0] o_write_cmd_count
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an item without a framebuffer write carries zero address and byte
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fb_write) |-> (o_fb_address == 16'd0 && o_fb_byte == 8'd0))
        else $error("address or byte set on an item with no write");

    // input backs up only when a full result is held by the output stall
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_fb_write)
            && $stable(o_fb_address) && $stable(o_fb_byte) && $stable(o_write_cmd_count)))
        else $error("stalled result changed");

endmodule

bind lcd_window_write_controller_top lcdw_checker u_lcdw_checker (.*);

// File: tb/sv/lcd_window_write_controller_top_test.sv
// self-checking testbench for the lcd window write controller
module lcd_window_write_controller_top_test;

    import lcdw_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 500;
    localparam int REPORT_MAX   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_write_strobe;
    logic        i_data_select;
    logic        i_chip_select_n;
    logic [7:0]  i_bus_data;
    logic        i_take_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_fb_write;
    logic [15:0] o_fb_address;
    logic [7:0]  o_fb_byte;
    logic [31:0] o_write_cmd_count;

    // predicted controller state
    logic        prev_strobe;
    logic [7:0]  cur_cmd;
    logic [8:0]  wr_idx;
    logic [7:0]  win_col_lo;
    logic [7:0]  win_col_hi;
    logic [7:0]  win_row_lo;
    logic [7:0]  win_row_hi;
    logic [7:0]  wr_row;
    logic [31:0] memwr_count;

    t_out_item   expected_fb_q[$];
    int          mismatches;
    int          samples_sent;
    int          quiet_cycles;
    logic        idle_on;
    int          stall_left;

    lcd_window_write_controller_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_write_strobe    (i_write_strobe),
        .i_data_select     (i_data_select),
        .i_chip_select_n   (i_chip_select_n),
        .i_bus_data        (i_bus_data),
        .i_take_count      (i_take_count),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_fb_write        (o_fb_write),
        .o_fb_address      (o_fb_address),
        .o_fb_byte         (o_fb_byte),
        .o_write_cmd_count (o_write_cmd_count)
    );

    always #2 i_clk = ~i_clk;

    // address-set parameter bytes 1 and 3, counter saturates
    function void window_param(input logic [7:0] data, input logic [7:0] lim,
                               inout logic [7:0] lo_v, inout logic [7:0] hi_v);
        if (wr_idx == IDX_START_PARAM) begin
            lo_v = (data > lim) ? lim : data;
        end else if (wr_idx == IDX_END_PARAM) begin
            hi_v = (data > lim) ? lim : data;
        end
        if (wr_idx < IDX_MAX) begin
            wr_idx = wr_idx + 9'd1;
        end
    endfunction

    function void predict_bus_sample(input logic strobe, input logic dsel, input logic csn,
                                     input logic [7:0] data, input logic take);
        t_out_item   res;
        logic        latch;
        logic        memwr_cmd;
        logic [31:0] row_addr;
        res = '0;
        res.write_cmd_count = memwr_count;
        latch = strobe && !prev_strobe && !csn;
        memwr_cmd = 1'b0;
        if (latch && !dsel) begin
            cur_cmd = data;
            wr_idx = '0;
            if (data == OP_MEMWR) begin
                wr_row = win_row_lo;
                wr_idx = {win_col_lo, 1'b0};
                memwr_cmd = 1'b1;
            end
        end else if (latch) begin
            case (cur_cmd)
                OP_COLSET: window_param(data, COL_LIMIT, win_col_lo, win_col_hi);
                OP_ROWSET: window_param(data, ROW_LIMIT, win_row_lo, win_row_hi);
                OP_MEMWR: begin
                    res.fb_write = 1'b1;
                    res.fb_byte = data;
                    row_addr = (32'(wr_row) << ROW_SHIFT) + 32'(wr_idx);
                    res.fb_address = 16'(row_addr & ((32'd1 << ADDR_BITS) - 32'd1));
                    wr_idx = wr_idx + 9'd1;
                    // past the right edge of the window: next row, wrap rows too
                    if (wr_idx > {win_col_hi, 1'b1}) begin
                        wr_idx = {win_col_lo, 1'b0};
                        wr_row = wr_row + 8'd1;
                        if (wr_row > win_row_hi) begin
                            wr_row = win_row_lo;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (take) begin
            memwr_count = '0;
        end
        if (memwr_cmd) begin
            memwr_count = memwr_count + 32'd1;
        end
        prev_strobe = strobe;
        expected_fb_q.push_back(res);
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (!idle_on || r < 12) begin
            return 0;
        end
        return (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic strobe, input logic dsel, input logic csn,
                             input logic [7:0] data, input logic take);
        int gap;
        i_in_valid      <= 1'b1;
        i_write_strobe  <= strobe;
        i_data_select   <= dsel;
        i_chip_select_n <= csn;
        i_bus_data      <= data;
        i_take_count    <= take;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_bus_sample(strobe, dsel, csn, data, take);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one strobe cycle on the bus: low sample, then the latching high sample
    task automatic bus_write(input logic dsel, input logic [7:0] data, input logic take);
        send_item(1'b0, dsel, 1'b0, 8'($urandom_range(0, 255)), 1'b0);
        send_item(1'b1, dsel, 1'b0, data, take);
    endtask

    function logic [7:0] pick_coord(input logic [7:0] lim);
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(int'(lim) + 1, 255));
            1: return lim;
            2: return 8'h00;
            3: return 8'($urandom_range(0, int'(lim)));
            default: return 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_default_window();
        bus_write(1'b0, OP_MEMWR, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'hFF, 1'b0);
    endtask

    task automatic test_window_clamp();
        // both windows collapse to a single column and row at the clamp limits, so every second byte wraps
        bus_write(1'b0, OP_COLSET, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'hFF, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'hFF, 1'b0);
        bus_write(1'b1, 8'h10, 1'b0);
        bus_write(1'b0, OP_ROWSET, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'hFF, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'hFF, 1'b0);
        bus_write(1'b0, OP_MEMWR, 1'b0);
        bus_write(1'b1, 8'hA5, 1'b0);
        bus_write(1'b1, 8'h5A, 1'b0);
    endtask

    task automatic test_ignored_bytes();
        bus_write(1'b0, OP_NOP, 1'b0);
        bus_write(1'b1, 8'h55, 1'b0);
        bus_write(1'b0, 8'hA5, 1'b0);
        bus_write(1'b1, 8'h12, 1'b0);
        bus_write(1'b0, OP_MEMWR, 1'b0);
        // edge with chip select high, then strobe held high
        send_item(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        send_item(1'b1, 1'b1, 1'b1, 8'h77, 1'b0);
        send_item(1'b1, 1'b1, 1'b0, 8'h66, 1'b0);
        bus_write(1'b1, 8'h99, 1'b0);
    endtask

    task automatic test_count_read();
        bus_write(1'b0, OP_MEMWR, 1'b0);
        send_item(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
        bus_write(1'b0, OP_MEMWR, 1'b0);
        bus_write(1'b0, OP_MEMWR, 1'b1);
        bus_write(1'b0, OP_MEMWR, 1'b0);
        send_item(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
    endtask

    task automatic test_param_saturation();
        bus_write(1'b0, OP_COLSET, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'h04, 1'b0);
        bus_write(1'b1, 8'h00, 1'b0);
        bus_write(1'b1, 8'h05, 1'b0);
        // a wrapping counter would hit the start parameter again
        repeat (512) bus_write(1'b1, 8'hFF, 1'b0);
        bus_write(1'b0, OP_MEMWR, 1'b0);
        bus_write(1'b1, 8'h3C, 1'b0);
        bus_write(1'b1, 8'hC3, 1'b0);
    endtask

    task automatic test_drain_pause();
        bus_write(1'b0, OP_MEMWR, 1'b0);
        repeat (6) bus_write(1'b1, 8'($urandom_range(0, 255)), 1'b0);
        i_in_valid <= 1'b0;
        wait (expected_fb_q.size() == 0);
        @(posedge i_clk);
        repeat (6) bus_write(1'b1, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int n;
        logic [7:0] cmd;
        stop_at = samples_sent + RANDOM_ITEMS;
        while (samples_sent < stop_at) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    bus_write(1'b0, OP_COLSET, $urandom_range(0, 19) == 0);
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
                    repeat (n) bus_write(1'b1, pick_coord(COL_LIMIT), $urandom_range(0, 19) == 0);
                end
                2: begin
                    bus_write(1'b0, OP_ROWSET, $urandom_range(0, 19) == 0);
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
                    repeat (n) bus_write(1'b1, pick_coord(ROW_LIMIT), $urandom_range(0, 19) == 0);
                end
                3, 4, 5, 6: begin
                    bus_write(1'b0, OP_MEMWR, $urandom_range(0, 19) == 0);
                    n = $urandom_range(1, 40);
                    repeat (n) begin
                        bus_write(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_item(1'($urandom), 1'($urandom), 1'($urandom),
                                  8'($urandom_range(0, 255)), 1'($urandom));
                    end
                end
                8: begin
                    cmd = 8'($urandom_range(0, 255));
                    bus_write(1'b0, cmd, 1'b0);
                    repeat ($urandom_range(1, 5)) bus_write(1'b1, 8'($urandom_range(0, 255)), 1'b0);
                end
                default: begin
                    // broken strobes: chip select high or strobe never dropped
                    repeat ($urandom_range(1, 4)) begin
                        send_item(1'b0, 1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0);
                        send_item(1'b1, 1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0);
                        send_item(1'b1, 1'($urandom), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
                    end
                end
            endcase
        end
    endtask

    // receiver stall: runs of random length, mostly short
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!idle_on || $urandom_range(0, 2) != 0) begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b1;
            stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_fb_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected item: wr=%0d addr=%h byte=%h cnt=%0d",
                             o_fb_write, o_fb_address, o_fb_byte, o_write_cmd_count);
                end
            end else begin
                want = expected_fb_q.pop_front();
                if (o_fb_write !== want.fb_write || o_fb_address !== want.fb_address ||
                    o_fb_byte !== want.fb_byte || o_write_cmd_count !== want.write_cmd_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display({"mismatch: exp wr=%0d addr=%h byte=%h cnt=%0d",
                                  " got wr=%0d addr=%h byte=%h cnt=%0d"},
                                 want.fb_write, want.fb_address, want.fb_byte,
                                 want.write_cmd_count, o_fb_write, o_fb_address,
                                 o_fb_byte, o_write_cmd_count);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_write_strobe  <= 1'b0;
        i_data_select   <= 1'b0;
        i_chip_select_n <= 1'b1;
        i_bus_data      <= 8'h00;
        i_take_count    <= 1'b0;
        i_out_stall     <= 1'b0;
        quiet_cycles    = 0;
        stall_left      = 0;
        mismatches      = 0;
        samples_sent    = 0;
        idle_on         = 1'b0;
        prev_strobe     = 1'b0;
        cur_cmd         = OP_NOP;
        wr_idx          = '0;
        win_col_lo      = 8'h00;
        win_col_hi      = COL_END_RST;
        win_row_lo      = 8'h00;
        win_row_hi      = ROW_END_RST;
        wr_row          = 8'h00;
        memwr_count     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_window_clamp();
        test_ignored_bytes();
        test_count_read();
        idle_on = 1'b1;
        test_param_saturation();
        test_drain_pause();
        test_random_traffic();

        i_in_valid <= 1'b0;
        wait (expected_fb_q.size() == 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
